// File: rtl/sds_pkg.sv
`timescale 1ns / 1ps
// Package for the scan dwell sequencer: codes, widths, result struct.
// No dependencies; imported by every module of the block.
package sds_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int TU_SHIFT_DEF     = 10;

    localparam int TIME_W     = 48;
    localparam int TU_W       = 16;
    localparam int COUNT_W    = 5;
    localparam int SLOT_IN_W  = 4;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DWELL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 3'd4;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_RESET  = 2'd2,
        KIND_LOAD   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_STARTED  = 3'd0,
        ST_BUSY     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_CONTINUE = 3'd3,
        ST_NEXT     = 3'd4,
        ST_PROBE    = 3'd5,
        ST_FINISHED = 3'd6,
        ST_IGNORED  = 3'd7
    } status_t;

    // per-request result, short of the channel number read from the table
    typedef struct packed {
        status_t                status;
        logic                   running;
        logic                   armed;
        logic [TIME_W-1:0]      deadline;
        logic [SLOT_IN_W-1:0]   slot;
    } sds_result_t;

endpackage

// File: rtl/sds_chan_mem.sv
`timescale 1ns / 1ps
// Channel list RAM: one write port, one registered read port.
// Same-address write and read in one cycle returns the new data.
module sds_chan_mem
    import sds_pkg::*;
#(
    parameter int DEPTH = MAX_CHANNELS_DEF,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CHAN_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [CHAN_W-1:0] rdata
);

    logic [CHAN_W-1:0] mem [DEPTH];
    logic [CHAN_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sds_ctrl.sv
`timescale 1ns / 1ps
// Scan control: config registers, scan state registers and the per-request
// next-state logic. Drives the channel RAM ports. Uses sds_pkg.
module sds_ctrl
    import sds_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TU_SHIFT     = TU_SHIFT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_fire,
    input  kind_t                 req_kind,
    input  logic [TIME_W-1:0]     req_now,
    input  logic [SLOT_IN_W-1:0]  req_slot,
    input  logic [CHAN_W-1:0]     req_chan,
    output logic                  mem_we,
    output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] mem_waddr,
    output logic [CHAN_W-1:0]     mem_wdata,
    output logic                  mem_re,
    output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] mem_raddr,
    output sds_result_t           result
);

    localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [7:0] MAX_CNT = 8'(MAX_CHANNELS);

    logic [TU_W-1:0]    min_dwell_reg, max_dwell_reg, probe_wait_reg;
    logic               active_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               running_reg, running_next;
    logic [SLOT_W-1:0]  slot_index_reg, slot_index_next;
    logic [TIME_W-1:0]  dwell_start_reg, dwell_start_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic               armed_reg, armed_next;
    status_t            status;

    logic [TIME_W-1:0]  min_us, max_us, probe_us, first_us, elapsed;
    logic [TIME_W-1:0]  add_base, add_off, add_sum;
    logic               max_hit, min_hit, probe_hit, restart;
    logic [7:0]         used_cnt, slot_inc_ext;
    logic [SLOT_W-1:0]  slot_inc;
    logic               load_ok;
    logic [IDX_W+SLOT_IN_W-1:0] wslot_wide;
    logic [IDX_W+SLOT_W-1:0]    rslot_wide;
    logic [SLOT_W+SLOT_IN_W-1:0] oslot_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dwell_reg  <= '0;
            max_dwell_reg  <= '0;
            probe_wait_reg <= '0;
            active_reg     <= 1'b0;
            count_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_DWELL:  min_dwell_reg  <= cfg_wdata;
                CFG_MAX_DWELL:  max_dwell_reg  <= cfg_wdata;
                CFG_PROBE_WAIT: probe_wait_reg <= cfg_wdata;
                CFG_ACTIVE:     active_reg     <= cfg_wdata[0];
                CFG_CHAN_COUNT: count_reg      <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // limits in microseconds
    assign min_us   = {{(TIME_W-TU_W){1'b0}}, min_dwell_reg} << TU_SHIFT;
    assign max_us   = {{(TIME_W-TU_W){1'b0}}, max_dwell_reg} << TU_SHIFT;
    assign probe_us = {{(TIME_W-TU_W){1'b0}}, probe_wait_reg} << TU_SHIFT;
    assign first_us = active_reg ? probe_us : min_us;

    assign elapsed   = req_now - dwell_start_reg;
    assign max_hit   = (elapsed >= max_us);
    assign min_hit   = (elapsed >= min_us);
    assign probe_hit = (elapsed >= probe_us);

    assign used_cnt     = ({3'b0, count_reg} > MAX_CNT) ? MAX_CNT : {3'b0, count_reg};
    assign slot_inc     = slot_index_reg + SLOT_W'(1);
    assign slot_inc_ext = 8'(slot_inc);

    // one shared adder for every deadline
    assign restart  = (req_kind == KIND_START) || max_hit;
    assign add_base = restart ? req_now : dwell_start_reg;
    assign add_off  = restart ? first_us : (min_hit ? max_us : min_us);
    assign add_sum  = add_base + add_off;

    assign load_ok    = ({4'b0, req_slot} < MAX_CNT);
    assign wslot_wide = {{IDX_W{1'b0}}, req_slot};

    always_comb begin
        running_next     = running_reg;
        slot_index_next  = slot_index_reg;
        dwell_start_next = dwell_start_reg;
        deadline_next    = deadline_reg;
        armed_next       = armed_reg;
        status           = ST_IGNORED;
        unique case (req_kind)
            KIND_START: begin
                if (running_reg) begin
                    status = ST_BUSY;
                end else if (used_cnt == 8'd0 || max_dwell_reg < min_dwell_reg) begin
                    status = ST_INVALID;
                end else begin
                    running_next     = 1'b1;
                    slot_index_next  = '0;
                    dwell_start_next = req_now;
                    deadline_next    = add_sum;
                    armed_next       = 1'b1;
                    status           = ST_STARTED;
                end
            end
            KIND_EXPIRY: begin
                if (!running_reg) begin
                    status = ST_IGNORED;
                end else if (max_hit) begin
                    if (slot_inc_ext >= used_cnt) begin
                        running_next     = 1'b0;
                        slot_index_next  = '0;
                        dwell_start_next = '0;
                        deadline_next    = '0;
                        armed_next       = 1'b0;
                        status           = ST_FINISHED;
                    end else begin
                        slot_index_next  = slot_inc;
                        dwell_start_next = req_now;
                        deadline_next    = add_sum;
                        armed_next       = 1'b1;
                        status           = ST_NEXT;
                    end
                end else if (min_hit) begin
                    deadline_next = add_sum;
                    armed_next    = 1'b1;
                    status        = ST_CONTINUE;
                end else if (active_reg && probe_hit) begin
                    deadline_next = add_sum;
                    armed_next    = 1'b1;
                    status        = ST_PROBE;
                end else begin
                    status = ST_CONTINUE;
                end
            end
            KIND_RESET: begin
                running_next     = 1'b0;
                slot_index_next  = '0;
                dwell_start_next = '0;
                deadline_next    = '0;
                armed_next       = 1'b0;
            end
            KIND_LOAD: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b0;
            slot_index_reg  <= '0;
            dwell_start_reg <= '0;
            deadline_reg    <= '0;
            armed_reg       <= 1'b0;
        end else if (req_fire) begin
            running_reg     <= running_next;
            slot_index_reg  <= slot_index_next;
            dwell_start_reg <= dwell_start_next;
            deadline_reg    <= deadline_next;
            armed_reg       <= armed_next;
        end
    end

    // table read follows the position after this request
    assign rslot_wide = {{IDX_W{1'b0}}, slot_index_next};
    assign oslot_wide = {{SLOT_IN_W{1'b0}}, slot_index_next};

    assign mem_we    = req_fire && (req_kind == KIND_LOAD) && load_ok;
    assign mem_waddr = wslot_wide[IDX_W-1:0];
    assign mem_wdata = req_chan;
    assign mem_re    = req_fire;
    assign mem_raddr = rslot_wide[IDX_W-1:0];

    assign result.status   = status;
    assign result.running  = running_next;
    assign result.armed    = armed_next;
    assign result.deadline = armed_next ? deadline_next : '0;
    assign result.slot     = running_next ? oslot_wide[SLOT_IN_W-1:0] : '0;

endmodule

// File: rtl/sds_out.sv
`timescale 1ns / 1ps
// Output register of the result stream; joins the registered table read.
// Uses sds_pkg.
module sds_out
    import sds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_fire,
    input  sds_result_t          result,
    input  logic [CHAN_W-1:0]    mem_rdata,
    output logic                 take_ok,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [2:0]           m_tuser
);

    logic        valid_reg;
    sds_result_t res_reg;
    logic [CHAN_W-1:0] chan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req_fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_fire) begin
            res_reg <= result;
        end
    end

    // new request only when no result is held or the held result leaves this cycle
    assign take_ok  = aresetn && (!valid_reg || m_tready);
    assign chan     = res_reg.running ? mem_rdata : '0;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'b0, res_reg.slot, chan, res_reg.deadline, res_reg.armed};

endmodule

// File: rtl/scan_dwell_sequencer.sv
`timescale 1ns / 1ps
// Scan dwell sequencer top level. The result is valid in the cycle after the request is taken.
// Throughput: one request per cycle; the channel RAM's single read per cycle and the
// output register set it, and back-pressure stalls intake only while a result is held.
// Reset (aresetn, synchronous, active low) clears the config, scan state and output valid
// registers at once; the channel table RAM is not cleared and needs no clearing pass.
module scan_dwell_sequencer
    import sds_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TU_SHIFT     = TU_SHIFT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // now_us[47:0], slot[51:48], channel_number[59:52]
    input  logic [1:0]            s_tuser,  // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // timer_armed[0], deadline_us[48:1],
                                            // current_channel[56:49], current_slot[60:57]
    output logic [2:0]            m_tuser   // status[2:0]
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic              req_fire, take_ok;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [CHAN_W-1:0] mem_wdata, mem_rdata;
    sds_result_t       result;

    assign s_tready = take_ok;
    assign req_fire = s_tvalid && take_ok;

    sds_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .TU_SHIFT     (TU_SHIFT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_fire  (req_fire),
        .req_kind  (kind_t'(s_tuser)),
        .req_now   (s_tdata[47:0]),
        .req_slot  (s_tdata[51:48]),
        .req_chan  (s_tdata[59:52]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .result    (result)
    );

    sds_chan_mem #(
        .DEPTH (MAX_CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sds_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_fire  (req_fire),
        .result    (result),
        .mem_rdata (mem_rdata),
        .take_ok   (take_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: rtl/sds_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the scan dwell sequencer, bound to the top level.
// Uses sds_pkg status codes.
module sds_checker
    import sds_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [2:0]           m_tuser
);

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a reset request gives one disarmed, ignored result next cycle
    a_reset_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_RESET) |=>
            (m_tvalid && m_tuser == ST_IGNORED && !m_tdata[0]))
        else $error("reset request gave wrong result");

    a_disarmed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[48:1] == 48'd0))
        else $error("deadline reported while disarmed");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FINISHED) |-> (m_tdata[60:49] == 12'd0 && !m_tdata[0]))
        else $error("finished result not idle");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind scan_dwell_sequencer sds_checker u_sds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/scan_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the scan dwell sequencer bench: scan-state predictor and result checker.
// Depends on sds_pkg for widths, request kinds, status codes and register indexes.
package scan_check_pkg;
    import sds_pkg::*;

    typedef struct {
        status_t               status;
        bit                    armed;
        bit [TIME_W-1:0]       deadline;
        bit [CHAN_W-1:0]       chan;
        bit [SLOT_IN_W-1:0]    slot;
    } scan_outcome_t;

    class scan_scoreboard;
        bit [TU_W-1:0]    min_tu, max_tu, probe_tu;
        bit               active;
        bit [COUNT_W-1:0] count;

        bit               running;
        bit [COUNT_W-1:0] pos;
        bit [TIME_W-1:0]  dwell_t0, due_t;
        bit               armed;
        bit [CHAN_W-1:0]  chan_tab [MAX_CHANNELS_DEF];

        scan_outcome_t    due_results [$];
        int               errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_DWELL:  min_tu = data;
                CFG_MAX_DWELL:  max_tu = data;
                CFG_PROBE_WAIT: probe_tu = data;
                CFG_ACTIVE:     active = data[0];
                CFG_CHAN_COUNT: count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [TIME_W-1:0] span(bit [TU_W-1:0] tu);
            bit [TIME_W-1:0] v = TIME_W'(tu);
            return v << TU_SHIFT_DEF;
        endfunction

        function bit [COUNT_W-1:0] used();
            return (count > MAX_CHANNELS_DEF) ? COUNT_W'(MAX_CHANNELS_DEF) : count;
        endfunction

        function void arm(bit [TU_W-1:0] tu);
            due_t = dwell_t0 + span(tu);
            armed = 1'b1;
        endfunction

        function void drop();
            running  = 1'b0;
            pos      = '0;
            dwell_t0 = '0;
            due_t    = '0;
            armed    = 1'b0;
        endfunction

        function void begin_dwell(bit [TIME_W-1:0] now);
            dwell_t0 = now;
            arm(active ? probe_tu : min_tu);
        endfunction

        // order matters: max dwell, then min dwell, then probe delay
        function status_t on_timer(bit [TIME_W-1:0] now);
            bit [TIME_W-1:0] gone;
            if (!running)
                return ST_IGNORED;
            gone = now - dwell_t0;
            if (gone >= span(max_tu)) begin
                pos++;
                if (pos >= used()) begin
                    drop();
                    return ST_FINISHED;
                end
                begin_dwell(now);
                return ST_NEXT;
            end
            if (gone >= span(min_tu)) begin
                arm(max_tu);
                return ST_CONTINUE;
            end
            if (active && gone >= span(probe_tu)) begin
                arm(min_tu);
                return ST_PROBE;
            end
            return ST_CONTINUE;
        endfunction

        function void take_request(kind_t kind, bit [TIME_W-1:0] now,
                                   bit [SLOT_IN_W-1:0] slot, bit [CHAN_W-1:0] chan);
            scan_outcome_t e;
            case (kind)
                KIND_START: begin
                    if (running)
                        e.status = ST_BUSY;
                    else if (used() == 0 || max_tu < min_tu)
                        e.status = ST_INVALID;
                    else begin
                        running = 1'b1;
                        pos = '0;
                        begin_dwell(now);
                        e.status = ST_STARTED;
                    end
                end
                KIND_EXPIRY: e.status = on_timer(now);
                KIND_RESET: begin
                    drop();
                    e.status = ST_IGNORED;
                end
                default: begin
                    chan_tab[slot] = chan;
                    e.status = ST_IGNORED;
                end
            endcase
            e.armed    = armed;
            e.deadline = armed ? due_t : '0;
            if (running && pos < MAX_CHANNELS_DEF) begin
                e.chan = chan_tab[pos[SLOT_IN_W-1:0]];
                e.slot = pos[SLOT_IN_W-1:0];
            end else begin
                e.chan = '0;
                e.slot = running ? pos[SLOT_IN_W-1:0] : '0;
            end
            due_results = {due_results, e};
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        // m_tdata: armed[0], deadline[48:1], channel[56:49], slot[60:57], zeros above
        function void check_result(logic [2:0] st, logic [M_TDATA_W-1:0] td);
            scan_outcome_t e;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual status %0h data %0h",
                         $time, st, td);
                return;
            end
            e = due_results.pop_front();
            compare("status", 64'(e.status), 64'(st));
            compare("timer_armed", 64'(e.armed), 64'(td[0]));
            compare("deadline_us", 64'(e.deadline), 64'(td[48:1]));
            compare("current_channel", 64'(e.chan), 64'(td[56:49]));
            compare("current_slot", 64'(e.slot), 64'(td[60:57]));
            compare("tdata padding", '0, 64'(td[63:61]));
        endfunction
    endclass

endpackage

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top-level bench for scan_dwell_sequencer: directed scan sequences, then random phases
// under three idling regimes. Depends on sds_pkg, scan_check_pkg and the block's RTL.
module tb;
    import sds_pkg::*;
    import scan_check_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;

    scan_scoreboard  sb = new;
    int              src_idle_pct = 0;
    int              sink_idle_pct = 0;
    int              stall_run = 0;
    bit [TIME_W-1:0] clock_us = '0;

    scan_dwell_sequencer DUT (.*);

    always #6 aclk = ~aclk;

    // result side: check, random back-pressure, watchdog
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_run <= 0;
        end else if (stall_run < STALL_LIMIT) begin
            stall_run <= stall_run + 1;
        end else begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit [TIME_W-1:0] rand_time();
        bit [63:0] w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    task automatic send_req(input kind_t kind, input bit [TIME_W-1:0] now,
                            input bit [SLOT_IN_W-1:0] slot, input bit [CHAN_W-1:0] chan);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, chan, slot, now};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.take_request(kind, now, slot, chan);
        clock_us = now;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // all five registers; a scan may still be running across this
    task automatic program_regs(input bit [TU_W-1:0] mn, mx, pw, input bit act,
                                input bit [COUNT_W-1:0] cnt);
        bit [CFG_DATA_W-1:0] junk = CFG_DATA_W'($urandom);
        drain();
        if ($urandom_range(2) == 0)
            reg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_CHAN_COUNT + 1)),
                      junk);
        reg_write(CFG_MIN_DWELL, mn);
        reg_write(CFG_MAX_DWELL, mx);
        reg_write(CFG_PROBE_WAIT, pw);
        reg_write(CFG_ACTIVE, {junk[CFG_DATA_W-1:1], act});
        reg_write(CFG_CHAN_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt});
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed scans: starts while idle, expiries aimed at the deadline
    task automatic random_item();
        int              r = $urandom_range(99);
        int              sel = $urandom_range(19);
        kind_t           kind;
        bit [TIME_W-1:0] now;
        now = (sel == 0) ? rand_time() : clock_us + $urandom_range(3000);
        if (sb.running) begin
            if (r < 80) begin
                kind = KIND_EXPIRY;
                if (sel < 10)
                    now = sb.due_t;
                else if (sel < 14)
                    now = sb.due_t + $urandom_range(2047);
                else if (sel < 17)
                    now = sb.due_t - 1 - $urandom_range(1023);
                else if (sel < 19)
                    now = sb.dwell_t0 + $urandom_range(8000);
            end else if (r < 85)
                kind = KIND_START;
            else if (r < 90)
                kind = KIND_RESET;
            else
                kind = KIND_LOAD;
        end else begin
            if (r < 65) begin
                kind = KIND_START;
                if (sel > 16)
                    now = 48'hFFFF_FFFF_FFFF - $urandom_range(20000);
            end else if (r < 75)
                kind = KIND_EXPIRY;
            else if (r < 85)
                kind = KIND_RESET;
            else
                kind = KIND_LOAD;
        end
        send_req(kind, now, SLOT_IN_W'($urandom), CHAN_W'($urandom));
    endtask

    task automatic random_phase(input int n_items);
        bit [TU_W-1:0]    mn, mx, pw;
        bit [COUNT_W-1:0] cnt;
        int               pick = $urandom_range(19);
        mn = TU_W'($urandom_range(6));
        mx = TU_W'(mn + $urandom_range(6));
        pw = TU_W'($urandom_range(mn + 2));
        if (mn != 0 && $urandom_range(9) == 0)
            mx = TU_W'($urandom_range(mn - 1));
        if ($urandom_range(9) == 0) begin
            mn = '1;
            mx = '1;
            pw = '1;
        end
        if (pick == 0)
            cnt = '0;
        else if (pick < 3)
            cnt = COUNT_W'($urandom_range(31, 17));
        else if (pick < 11)
            cnt = COUNT_W'($urandom_range(4, 1));
        else
            cnt = COUNT_W'($urandom_range(16, 1));
        program_regs(mn, mx, pw, 1'($urandom_range(1)), cnt);
        repeat (n_items)
            random_item();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // idle block, empty list
        send_req(KIND_START, '0, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, 48'hFFFF_FFFF_FFFF, 4'hF, 8'hFF);
        send_req(KIND_LOAD, rand_time(), 4'd0, 8'h00);
        send_req(KIND_LOAD, rand_time(), 4'd1, 8'hFF);
        send_req(KIND_LOAD, rand_time(), 4'd2, 8'h5A);
        send_req(KIND_LOAD, rand_time(), 4'd3, 8'hA5);
        send_req(KIND_LOAD, rand_time(), 4'd15, 8'h3C);

        // max below min is refused
        program_regs(16'd2, 16'd1, 16'd0, 1'b0, 5'd3);
        send_req(KIND_START, 48'd100, 4'd0, 8'd0);

        // passive scan across the 48-bit wrap
        program_regs(16'd1, 16'd3, 16'd0, 1'b0, 5'd3);
        send_req(KIND_START, 48'hFFFF_FFFF_FF00, 4'd0, 8'd0);
        send_req(KIND_START, 48'hFFFF_FFFF_FF10, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.dwell_t0 + 100, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.dwell_t0 + 1024, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t, 4'd0, 8'd0);
        // list cut to one entry mid-scan: next max-dwell expiry finishes
        program_regs(16'd1, 16'd3, 16'd0, 1'b0, 5'd1);
        send_req(KIND_EXPIRY, sb.dwell_t0 + 3072, 4'd0, 8'd0);

        // active scan: probe, min, max, then min already past skips probing
        program_regs(16'd2, 16'd4, 16'd1, 1'b1, 5'd4);
        send_req(KIND_START, 48'd1000, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.dwell_t0 + 3000, 4'd0, 8'd0);
        send_req(KIND_RESET, rand_time(), 4'd0, 8'd0);

        // largest dwell settings
        program_regs('1, '1, '1, 1'b0, 5'd4);
        send_req(KIND_START, 48'hFFFF_FFFF_FFFF, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t - 1, 4'd0, 8'd0);
        send_req(KIND_EXPIRY, sb.due_t, 4'd0, 8'd0);
        send_req(KIND_RESET, rand_time(), 4'd0, 8'd0);

        // fill the whole list so any count reads loaded entries
        src_idle_pct  = 16;
        sink_idle_pct = 75;
        for (int s = 0; s < MAX_CHANNELS_DEF; s++)
            send_req(KIND_LOAD, clock_us + $urandom_range(100), SLOT_IN_W'(s),
                     CHAN_W'($urandom));

        for (int regime = 0; regime < 3; regime++) begin
            src_idle_pct  = (regime == 0) ? 16 : (regime == 1) ? 75 : 0;
            sink_idle_pct = (regime == 0) ? 75 : (regime == 1) ? 16 : 0;
            for (int ph = 0; ph < 4; ph++)
                random_phase(34);
        end

        drain();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/sds_pkg.sv
rtl/sds_chan_mem.sv
rtl/sds_ctrl.sv
rtl/sds_out.sv
rtl/scan_dwell_sequencer.sv
rtl/sds_checker.sv
bench/scan_check_pkg.sv
bench/tb.sv
